>>> sv/nv12_nearest_neighbor_scaler_assert.svh
// Assertion macros shared by the scaler RTL.
`ifndef NV12_NEAREST_NEIGHBOR_SCALER_ASSERT_SVH
`define NV12_NEAREST_NEIGHBOR_SCALER_ASSERT_SVH
`ifndef ASSERT_OFF
`define NNS_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define NNS_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define NNS_ASSERT_IMPL(label, clk, rst, prop, msg)
`define NNS_ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

>>> sv/nns_pkg.sv
// ----------------------------------------------------------------------------
// nns_pkg
// Shared types and codes of the NV12 nearest-neighbor scaler.
// ----------------------------------------------------------------------------
`default_nettype none
package nns_pkg;
   localparam logic [1:0] CMD_WRITE  = 2'd0;
   localparam logic [1:0] CMD_COMMIT = 2'd1;
   localparam logic [1:0] CMD_READ   = 2'd2;
   localparam logic [1:0] CMD_NONE   = 2'd3;

   localparam logic [2:0] ST_FRAME    = 3'd0;
   localparam logic [2:0] ST_BLACK    = 3'd1;
   localparam logic [2:0] ST_ACCEPTED = 3'd2;
   localparam logic [2:0] ST_REJECTED = 3'd3;
   localparam logic [2:0] ST_RANGE    = 3'd4;

   localparam logic [7:0] BLACK_LUMA   = 8'd16;
   localparam logic [7:0] BLACK_CHROMA = 8'd128;

   localparam int REG_DST_WIDTH  = 0;
   localparam int REG_DST_HEIGHT = 1;

   // Largest source frame; the latched size registers are 9 bits wide.
   localparam int MAX_SRC_WIDTH  = 256;
   localparam int MAX_SRC_HEIGHT = 256;
   localparam int BANK_DEPTH     = (MAX_SRC_WIDTH * MAX_SRC_HEIGHT * 3) / 2;

   // Classified read transaction handed from front to back.
   typedef struct packed {
      logic        plane;
      logic [11:0] num_col;   // column numerator term (col or col/2)
      logic [11:0] den_col;   // dw or dw/2
      logic [11:0] num_row;   // row
      logic [11:0] den_row;   // dh or dh/2
      logic        col_lsb;
   } read_job_type;
endpackage
`default_nettype wire

>>> sv/nv12_nearest_neighbor_scaler.sv
// ----------------------------------------------------------------------------
// nv12_nearest_neighbor_scaler
// Double-buffered NV12 frame store with nearest-neighbor readout.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Writes give no
// result. Commits and reads that are out of range or come before any frame
// answer in the next cycle. A read from a frame puts its result on the rsp_
// ports after these steps: a register hands it to the read engine, the
// bit-serial divider runs twice (column, then row), then address build, bank
// read and the output register. Busy stays high until the result has been
// shown, so the next transaction is taken in the cycle after it. The receiver
// cannot stall: each result shows on rsp_ ports for one cycle with rsp_valid.
`default_nettype none
`include "nv12_nearest_neighbor_scaler_assert.svh"
module nv12_nearest_neighbor_scaler (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_command,
   input  wire logic [16:0] req_src_addr,
   input  wire logic [7:0]  req_src_data,
   input  wire logic [11:0] req_frame_width,
   input  wire logic [11:0] req_frame_height,
   input  wire logic        req_out_plane,
   input  wire logic [10:0] req_out_col,
   input  wire logic [10:0] req_out_row,
   output logic             rsp_valid,
   output logic [7:0]       rsp_pixel_byte,
   output logic [2:0]       rsp_status,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [11:0] csr_wdata
);
   import nns_pkg::*;
   localparam int DEPTH = BANK_DEPTH;
   localparam int AW = 17;

   logic [7:0]  bank0 [DEPTH];
   logic [7:0]  bank1 [DEPTH];
   logic [11:0] dw_ff, dh_ff;
   logic        sel_ff, present_ff, accept, commit_ok, job_push, job_take;
   logic        queued_ff, back_busy_ff;
   logic [8:0]  sw_ff, sh_ff;
   read_job_type job, q_ff;
   logic [AW-1:0] rd_addr;
   logic        rd_en, fv, bv;
   logic [7:0]  rd_ff, fb, bb;
   logic [2:0]  fs, bs;

   assign accept = start && !busy;
   // One outstanding read at a time keeps results in order.
   assign busy = queued_ff || back_busy_ff;

   nns_front u_front (
      .clock(clock), .reset(reset), .accept(accept), .command(req_command),
      .frame_width(req_frame_width), .frame_height(req_frame_height),
      .out_plane(req_out_plane), .out_col(req_out_col), .out_row(req_out_row),
      .dst_w(dw_ff), .dst_h(dh_ff), .frame_present(present_ff),
      .commit_ok(commit_ok), .job_push(job_push), .job(job),
      .res_valid(fv), .res_byte(fb), .res_status(fs));

   nns_back #(.DEPTH(DEPTH), .AW(AW)) u_back (
      .clock(clock), .reset(reset), .job_valid(queued_ff), .job(q_ff),
      .job_take(job_take), .src_w(sw_ff), .src_h(sh_ff), .rd_addr(rd_addr),
      .rd_en(rd_en), .rd_data(rd_ff), .res_valid(bv), .res_byte(bb), .res_status(bs));

   always_ff @(posedge clock) begin
      if (accept && req_command == CMD_WRITE && req_src_addr < AW'(DEPTH)) begin
         if (sel_ff) bank0[req_src_addr] <= req_src_data;
         else bank1[req_src_addr] <= req_src_data;
      end
      if (rd_en) rd_ff <= sel_ff ? bank1[rd_addr] : bank0[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (job_push) q_ff <= job;
      if (commit_ok) begin
         sw_ff <= req_frame_width[8:0]; sh_ff <= req_frame_height[8:0];
      end
      if (reset) begin
         dw_ff <= 12'd1920; dh_ff <= 12'd1080; sel_ff <= 1'b0; present_ff <= 1'b0;
         queued_ff <= 1'b0; back_busy_ff <= 1'b0; sw_ff <= '0; sh_ff <= '0;
      end else begin
         if (csr_we && csr_index == 1'(REG_DST_WIDTH)) dw_ff <= csr_wdata;
         if (csr_we && csr_index == 1'(REG_DST_HEIGHT)) dh_ff <= csr_wdata;
         if (commit_ok) begin
            sel_ff <= !sel_ff; present_ff <= 1'b1;
         end
         if (job_push) queued_ff <= 1'b1;
         else if (job_take) queued_ff <= 1'b0;
         if (job_take) back_busy_ff <= 1'b1;
         else if (bv) back_busy_ff <= 1'b0;
      end
   end

   assign rsp_valid = fv || bv;
   assign rsp_pixel_byte = bv ? bb : fb;
   assign rsp_status = bv ? bs : fs;

   `NNS_ASSERT_NEVER(a_res_clash, clock, reset, fv && bv, "result collision")
   `NNS_ASSERT_NEVER(a_push_busy, clock, reset, job_push && busy, "push while busy")
   `NNS_ASSERT_IMPL(a_push_q, clock, reset, job_push |=> queued_ff, "queue")
endmodule
`default_nettype wire

>>> sv/nns_divider.sv
// ----------------------------------------------------------------------------
// nns_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module nns_divider #(
   parameter int NW = 24,
   parameter int DW = 12
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [NW-1:0] numer,
   input  wire logic [DW-1:0] denom,
   output logic               done,
   output logic [NW-1:0]      quot
);
   localparam int CW = $clog2(NW + 1);
   logic [NW-1:0] q_ff, q_in;
   logic [DW:0]   r_ff, r_in;
   logic [DW-1:0] d_ff, d_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          run_ff, run_in, done_ff, done_in;
   logic [DW+1:0] trial;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; cnt_in = cnt_ff;
      run_in = run_ff; done_in = 1'b0;
      trial = {r_ff, q_ff[NW-1]} - {2'b00, d_ff};
      if (start) begin
         q_in = numer; r_in = '0; d_in = denom;
         cnt_in = CW'(NW); run_in = 1'b1;
      end else if (run_ff) begin
         if (!trial[DW+1]) begin
            r_in = trial[DW:0];
            q_in = {q_ff[NW-2:0], 1'b1};
         end else begin
            r_in = {r_ff[DW-1:0], q_ff[NW-1]};
            q_in = {q_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            run_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; cnt_ff <= cnt_in;
      if (reset) begin
         run_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         run_ff <= run_in; done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = q_ff;
endmodule
`default_nettype wire

>>> sv/nns_back.sv
// ----------------------------------------------------------------------------
// nns_back
// Read engine: two divisions, address build, bank read, result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "nv12_nearest_neighbor_scaler_assert.svh"
module nns_back #(
   parameter int DEPTH = 98304,
   parameter int AW = 17
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  job_valid,
   input  wire nns_pkg::read_job_type job,
   output logic                       job_take,
   input  wire logic [8:0]            src_w,
   input  wire logic [8:0]            src_h,
   output logic [AW-1:0]              rd_addr,
   output logic                       rd_en,
   input  wire logic [7:0]            rd_data,
   output logic                       res_valid,
   output logic [7:0]                 res_byte,
   output logic [2:0]                 res_status
);
   import nns_pkg::*;
   typedef enum logic [2:0] {S_IDLE, S_DIVC, S_DIVR, S_ADDR, S_MEM, S_OUT} state_type;
   state_type     state_ff;
   read_job_type  job_ff;
   logic [11:0]   qc_ff, qr_ff;
   logic [AW:0]   idx_ff;
   logic          dstart;
   logic [23:0]   dnum, dquot;
   logic [11:0]   dden;
   logic          ddone;
   logic [8:0]    sh_eff;
   logic [AW:0]   idx_in;
   logic          valid_ff;
   logic [7:0]    byte_ff;
   logic [2:0]    stat_ff;

   assign sh_eff = job_ff.plane ? {1'b0, src_h[8:1]} : src_h;
   nns_divider #(.NW(24), .DW(12)) u_div (
      .clock(clock), .reset(reset), .start(dstart), .numer(dnum), .denom(dden),
      .done(ddone), .quot(dquot));

   always_comb begin
      dstart = 1'b0; dnum = '0; dden = job_ff.den_col;
      if (state_ff == S_IDLE && job_valid) begin
         dstart = 1'b1;
         dnum = 24'(job.num_col) * 24'(job.plane ? {1'b0, src_w[8:1]} : src_w);
         dden = job.den_col;
      end else if (state_ff == S_DIVC && ddone) begin
         dstart = 1'b1;
         dnum = 24'(job_ff.num_row) * 24'(sh_eff);
         dden = job_ff.den_row;
      end
      if (job_ff.plane)
         idx_in = (AW+1)'(src_w) * (AW+1)'(src_h) + (AW+1)'(qr_ff) * (AW+1)'(src_w)
                + (AW+1)'({qc_ff, 1'b0}) + (AW+1)'(job_ff.col_lsb);
      else
         idx_in = (AW+1)'(qr_ff) * (AW+1)'(src_w) + (AW+1)'(qc_ff);
   end

   assign job_take = (state_ff == S_IDLE) && job_valid;
   // The address settles in S_ADDR; the bank is read in S_MEM.
   assign rd_en = (state_ff == S_MEM) && (idx_ff < (AW+1)'(DEPTH));
   assign rd_addr = idx_ff[AW-1:0];

   always_ff @(posedge clock) begin
      valid_ff <= 1'b0;
      case (state_ff)
         S_IDLE: if (job_valid) begin
            job_ff <= job; state_ff <= S_DIVC;
         end
         S_DIVC: if (ddone) begin
            qc_ff <= dquot[11:0]; state_ff <= S_DIVR;
         end
         S_DIVR: if (ddone) begin
            qr_ff <= dquot[11:0]; state_ff <= S_ADDR;
         end
         S_ADDR: begin
            idx_ff <= idx_in; state_ff <= S_MEM;
         end
         S_MEM: state_ff <= S_OUT;
         S_OUT: begin
            valid_ff <= 1'b1;
            if (idx_ff < (AW+1)'(DEPTH)) begin
               byte_ff <= rd_data; stat_ff <= ST_FRAME;
            end else begin
               byte_ff <= '0; stat_ff <= ST_RANGE;
            end
            state_ff <= S_IDLE;
         end
         default: state_ff <= S_IDLE;
      endcase
      if (reset) begin
         state_ff <= S_IDLE; valid_ff <= 1'b0;
      end
   end

   assign res_valid = valid_ff;
   assign res_byte = byte_ff;
   assign res_status = stat_ff;

   `NNS_ASSERT_IMPL(a_take_idle, clock, reset, job_take |=> state_ff == S_DIVC, "take")
   `NNS_ASSERT_IMPL(a_out_one, clock, reset, valid_ff |=> !valid_ff, "double result")
   `NNS_ASSERT_NEVER(a_rd_oob, clock, reset, rd_en && idx_ff >= (AW+1)'(DEPTH), "oob read")
endmodule
`default_nettype wire

>>> sv/nns_front.sv
// ----------------------------------------------------------------------------
// nns_front
// Command decode, commit check, read job build and fast answers.
// ----------------------------------------------------------------------------
`default_nettype none
`include "nv12_nearest_neighbor_scaler_assert.svh"
module nns_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire logic [1:0]            command,
   input  wire logic [11:0]           frame_width,
   input  wire logic [11:0]           frame_height,
   input  wire logic                  out_plane,
   input  wire logic [10:0]           out_col,
   input  wire logic [10:0]           out_row,
   input  wire logic [11:0]           dst_w,
   input  wire logic [11:0]           dst_h,
   input  wire logic                  frame_present,
   output logic                       commit_ok,
   output logic                       job_push,
   output nns_pkg::read_job_type      job,
   output logic                       res_valid,
   output logic [7:0]                 res_byte,
   output logic [2:0]                 res_status
);
   import nns_pkg::*;
   logic        bad_size, oor;
   logic        v_ff;
   logic [7:0]  b_ff;
   logic [2:0]  s_ff;
   logic [11:0] dw2, dh2;

   assign dw2 = {1'b0, dst_w[11:1]};
   assign dh2 = {1'b0, dst_h[11:1]};
   assign bad_size = frame_width == '0 || frame_height == '0
      || frame_width > 12'(MAX_SRC_WIDTH) || frame_height > 12'(MAX_SRC_HEIGHT)
      || frame_width[0] || frame_height[0];
   always_comb begin
      if (dst_w < 12'd2 || dst_h < 12'd2) oor = 1'b1;
      else if (!out_plane) oor = {1'b0, out_col} >= dst_w || {1'b0, out_row} >= dst_h;
      else oor = {1'b0, out_col} >= {dw2[10:0], 1'b0} || {1'b0, out_row} >= dh2;
      job.plane = out_plane;
      job.num_col = out_plane ? {2'b00, out_col[10:1]} : {1'b0, out_col};
      job.den_col = out_plane ? dw2 : dst_w;
      job.num_row = {1'b0, out_row};
      job.den_row = out_plane ? dh2 : dst_h;
      job.col_lsb = out_col[0];
   end
   assign commit_ok = accept && command == CMD_COMMIT && !bad_size;
   assign job_push = accept && command == CMD_READ && !oor && frame_present;

   always_ff @(posedge clock) begin
      v_ff <= 1'b0;
      if (accept && command == CMD_COMMIT) begin
         v_ff <= 1'b1; b_ff <= '0;
         s_ff <= bad_size ? ST_REJECTED : ST_ACCEPTED;
      end else if (accept && command == CMD_READ && (oor || !frame_present)) begin
         v_ff <= 1'b1;
         b_ff <= oor ? 8'd0 : (out_plane ? BLACK_CHROMA : BLACK_LUMA);
         s_ff <= oor ? ST_RANGE : ST_BLACK;
      end
      if (reset) v_ff <= 1'b0;
   end
   assign res_valid = v_ff;
   assign res_byte = b_ff;
   assign res_status = s_ff;

   `NNS_ASSERT_NEVER(a_push_commit, clock, reset, job_push && commit_ok, "both")
   `NNS_ASSERT_IMPL(a_commit_res, clock, reset, accept && command == CMD_COMMIT |=> v_ff, "commit")
   `NNS_ASSERT_NEVER(a_no_frame, clock, reset, job_push && !frame_present, "no frame")
endmodule
`default_nettype wire
